/* rtl/core/min_priority_queue_top_defines.svh */
// assertion macros for the min priority queue checker
`ifndef MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define MPQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("min priority queue check failed");

// condition that must never be seen out of reset
`define MPQ_NEVER(name, expr) \
  `MPQ_ASSERT(name, !(expr))

`endif

/* rtl/core/mpq_pkg.sv */
// shared types and constants of the min priority queue
`default_nettype none

package mpq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned OccW     = 5;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatOver  = 2'd1;
  localparam logic [1:0] StatUnder = 2'd2;

  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    logic        [1:0]      status;
    logic signed [31:0]     removed_value;
    logic signed [31:0]     removed_priority;
    logic        [OccW-1:0] occupancy;
    logic                   is_full;
    logic                   is_empty;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/mpq_cell.sv */
// one slot of the sorted queue: compare with the new item and shift
`default_nettype none

module mpq_cell (
  input  wire                 clk_i,
  input  mpq_pkg::cell_ctl_t  ctl_i,
  input  wire                 occ_i,
  input  wire                 left_gt_i,
  input  mpq_pkg::entry_t     left_i,
  input  mpq_pkg::entry_t     right_i,
  output logic                gt_o,
  output mpq_pkg::entry_t     data_o
);

  mpq_pkg::entry_t data_q, data_d;

  // held entry ranks behind the new item
  assign gt_o   = occ_i && ($signed(data_q.prio) > $signed(ctl_i.item.prio));
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        data_d = left_i;
      end else if (gt_o || !occ_i) begin
        data_d = ctl_i.item;
      end
    end else if (ctl_i.rem) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

/* rtl/core/min_priority_queue_top.sv */
// min priority queue: sorted row of shifting cells with request control
//
// usage
//   a request beat (insert, remove lowest, clear) is taken at a rising edge
//   with start high and busy low; busy stays low, so a request can be
//   issued on every clock
//   each request gives exactly one result beat on rsp_o, marked by done_o
//   for one cycle, in the cycle right after the request was taken
//   throughput: 1 request per cycle, set by the single
//   pass through the cell row (each cell compares against the new item and
//   picks its own, its left or its right neighbor's entry in that cycle)
//   the result carries status (ok, overflow, underflow), the removed entry
//   (zero when nothing left the queue) and occupancy with full and empty
//   flags after the request; entries of equal priority leave in the order
//   they came
//   reset clears the entry count and the result strobe; cell contents are
//   not reset and are never read above the count
//   the receiver cannot stall: a result beat is there for one cycle only
`default_nettype none

module min_priority_queue_top (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  mpq_pkg::req_t  req_i,
  output logic           done_o,
  output mpq_pkg::rsp_t  rsp_o
);

  localparam int unsigned N = mpq_pkg::Capacity;

  logic [mpq_pkg::CntW-1:0] count_q, count_d;
  logic                     done_q;
  mpq_pkg::rsp_t            rsp_q, rsp_d;

  mpq_pkg::cell_ctl_t ctl;
  mpq_pkg::entry_t    cell_data [N];
  logic [N-1:0]       cell_gt;
  logic [N-1:0]       cell_occ;

  logic accept, is_full_now, is_empty_now;

  assign busy         = 1'b0;
  assign accept       = start && !busy;
  assign is_full_now  = (count_q == mpq_pkg::CntW'(N));
  assign is_empty_now = (count_q == '0);

  // broadcast control: only requests that change the row reach the cells
  assign ctl.ins  = accept && (req_i.operation == mpq_pkg::OpInsert) && !is_full_now;
  assign ctl.rem  = accept && (req_i.operation == mpq_pkg::OpRemove) && !is_empty_now;
  assign ctl.item = '{value: req_i.item_value, prio: req_i.item_priority};

  // cell row, lowest priority number at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    mpq_pkg::entry_t left_data, right_data;
    logic            left_gt;

    assign cell_occ[i] = (mpq_pkg::CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_gt   = 1'b0;
      assign left_data = ctl.item;
    end else begin : g_mid
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    mpq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .occ_i     (cell_occ[i]),
      .left_gt_i (left_gt),
      .left_i    (left_data),
      .right_i   (right_data),
      .gt_o      (cell_gt[i]),
      .data_o    (cell_data[i])
    );
  end

  // entry count and result beat
  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (accept) begin
      case (req_i.operation)
        mpq_pkg::OpInsert: begin
          if (is_full_now) begin
            rsp_d.status = mpq_pkg::StatOver;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        mpq_pkg::OpRemove: begin
          if (is_empty_now) begin
            rsp_d.status = mpq_pkg::StatUnder;
          end else begin
            count_d                = count_q - 1'b1;
            rsp_d.removed_value    = cell_data[0].value;
            rsp_d.removed_priority = cell_data[0].prio;
          end
        end
        mpq_pkg::OpClear: begin
          count_d = '0;
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
    rsp_d.occupancy = mpq_pkg::OccW'(count_d);
    rsp_d.is_full   = (count_d == mpq_pkg::CntW'(N));
    rsp_d.is_empty  = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

/* rtl/core/mpq_checker.sv */
// port-level checks of the min priority queue, bound to the top level
`default_nettype none
`include "min_priority_queue_top_defines.svh"

module mpq_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            start,
  input wire            busy,
  input mpq_pkg::req_t  req_i,
  input wire            done_o,
  input mpq_pkg::rsp_t  rsp_o
);

  // every request beat gets its result beat on the next cycle
  `MPQ_ASSERT(a_req_gets_rsp, (start && !busy) |=> done_o)

  // no result beat without a request beat
  `MPQ_ASSERT(a_rsp_has_req, done_o |-> $past(start && !busy))

  // a queue cannot be full and empty at once
  `MPQ_NEVER(a_full_and_empty, done_o && rsp_o.is_full && rsp_o.is_empty)

  // an underflow leaves the queue empty and removes nothing
  `MPQ_ASSERT(a_underflow_clean,
    (done_o && (rsp_o.status == mpq_pkg::StatUnder)) |->
      (rsp_o.is_empty && (rsp_o.removed_value == 0) && (rsp_o.removed_priority == 0)))

endmodule

bind min_priority_queue_top mpq_checker u_mpq_checker (.*);

`default_nettype wire
